// File: rtl/core/mbu_pkg.sv
package mbu_pkg;

	// Store and read limits
	localparam int STORE_BITS    = 32;
	localparam int MAX_READ_BITS = 16;
	localparam int BYTE_W        = 8;
	localparam int COUNT_W       = 5;
	localparam int VALUE_W       = 16;
	localparam int HELD_OUT_W    = 6;
	localparam int HELD_W        = $clog2(STORE_BITS + 1);

	// Item commands
	typedef enum logic [0:0] {
		CMD_PUSH = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_FULL     = 2'd2,
		ST_BADCOUNT = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [BYTE_W-1:0]    data_byte;
		logic [COUNT_W-1:0]   bit_count;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]    value;
		status_t               status;
		logic [HELD_OUT_W-1:0] bits_held;
	} rsp_t;

endpackage

// File: rtl/core/msb_first_bit_unpacker_unit.sv
// MSB-first bit unpacker.
// Request channel (req_valid / req_stall / req): a push item appends
// req.data_byte to the bit store, most significant bit first; a read item
// takes req.bit_count bits (1..16) and returns them with the first stream
// bit in value bit 0. Every item gives exactly one response item on
// rsp_valid / rsp_stall / rsp, carrying value, status and bits_held.
// An accepted item sits in the input register, then moves to the output
// register and shows on rsp from then; a stall on rsp_stall can hold it in
// the input register before it moves.
// Throughput: one item per cycle while rsp is not stalled; the store update
// is a single shift and mask between the input and output registers.
// While the receiver stalls, the response holds and the input register
// still fills; req_stall rises only when both registers hold items.
// Reset (arst_n low) empties the store and drops any item in flight.
module msb_first_bit_unpacker_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mbu_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mbu_pkg::rsp_t  rsp
);
	import mbu_pkg::*;

	req_t                  req_s1;
	logic                  req_valid_s1;
	rsp_t                  rsp_s2;
	logic                  rsp_valid_s2;
	logic [STORE_BITS-1:0] store_q;
	logic [HELD_W-1:0]     held_q;

	logic                  s2_ready;
	logic                  s1_ready;
	logic                  advance;

	logic [STORE_BITS-1:0] store_nxt;
	logic [HELD_W-1:0]     held_nxt;
	rsp_t                  rsp_nxt;
	logic [HELD_W-1:0]     cnt_ext;
	logic [HELD_W-1:0]     rest;
	logic [VALUE_W-1:0]    chunk;
	logic [VALUE_W-1:0]    chunk_rev;
	logic                  push_full;
	logic                  bad_count;
	logic                  short_read;

	// Handshake
	assign s2_ready  = !rsp_valid_s2 || !rsp_stall;
	assign s1_ready  = !req_valid_s1 || s2_ready;
	assign advance   = req_valid_s1 && s2_ready;
	assign req_stall = !s1_ready;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// Read path: take the cnt oldest bits, then reverse them
	assign cnt_ext    = HELD_W'(req_s1.bit_count);
	assign rest       = held_q - cnt_ext;
	assign chunk      = VALUE_W'(store_q >> rest) & ~({VALUE_W{1'b1}} << req_s1.bit_count);
	assign push_full  = held_q > HELD_W'(STORE_BITS - BYTE_W);
	assign bad_count  = (req_s1.bit_count == '0)
		|| (req_s1.bit_count > COUNT_W'(MAX_READ_BITS));
	assign short_read = cnt_ext > held_q;

	always_comb begin
		for (int i = 0; i < VALUE_W; i++) begin
			chunk_rev[i] = chunk[VALUE_W-1-i];
		end
	end

	// Next state and response
	always_comb begin
		store_nxt      = store_q;
		held_nxt       = held_q;
		rsp_nxt.value  = '0;
		rsp_nxt.status = ST_OK;
		unique case (req_s1.cmd)
			CMD_PUSH: begin
				if (push_full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					store_nxt = {store_q[STORE_BITS-BYTE_W-1:0], req_s1.data_byte};
					held_nxt  = held_q + HELD_W'(BYTE_W);
				end
			end
			CMD_READ: begin
				priority if (bad_count) begin
					rsp_nxt.status = ST_BADCOUNT;
				end else if (short_read) begin
					rsp_nxt.status = ST_SHORT;
				end else begin
					rsp_nxt.value = chunk_rev
						>> (COUNT_W'(VALUE_W) - req_s1.bit_count);
					store_nxt     = store_q & ~({STORE_BITS{1'b1}} << rest);
					held_nxt      = rest;
				end
			end
			default: begin
				rsp_nxt.status = ST_OK;
			end
		endcase
		rsp_nxt.bits_held = HELD_OUT_W'(held_nxt);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Output register and bit store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
			store_q      <= '0;
			held_q       <= '0;
		end else begin
			if (s2_ready) begin
				rsp_valid_s2 <= req_valid_s1;
			end
			if (advance) begin
				store_q <= store_nxt;
				held_q  <= held_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_nxt;
		end
	end

endmodule
